FILE: sv/aes256_block_cipher_defines.svh
// ----------------------------------------------------------------------------
// AES-256 assertion macros
// Shared concurrent assertion shorthands for the cipher modules.
// ----------------------------------------------------------------------------
`ifndef AES256_BLOCK_CIPHER_DEFINES_SVH
`define AES256_BLOCK_CIPHER_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define AES_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled while in reset
`define AES_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/aes256_pkg.sv
// ----------------------------------------------------------------------------
// AES-256 package
// Types, S-box tables and round functions shared by the cipher modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package aes256_pkg;

   localparam int NUM_KEY_REGS = 4;
   localparam int NUM_ROWS     = 15;
   localparam int LAST_ROUND   = 14;
   localparam int LAST_WORD    = 59;
   localparam int FIRST_GEN    = 8;

   // register indexes of the configuration port
   localparam logic [2:0] CSR_KEY0 = 3'd0;
   localparam logic [2:0] CSR_MODE = 3'd4;

   typedef logic [3:0] row_type;

   // controller to datapath
   typedef struct packed {
      logic    capture;
      logic    round_en;
      logic    init;
      logic    last;
      logic    ram_we;
      logic    key_load;
      logic    key_gen;
      logic [5:0] gen_idx;
      row_type waddr;
      row_type raddr;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic cfg_wr;
      logic key_wr;
      logic decrypt;
   } status_type;

   localparam logic [7:0] SBOX [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   localparam logic [7:0] REV_SBOX [256] = '{
      8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
      8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
      8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
      8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
      8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
      8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
      8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
      8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
      8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
      8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
      8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
      8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
      8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
      8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
      8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
   };

   // multiply by x in GF(2^8)
   function automatic logic [7:0] xtime(input logic [7:0] b);
      return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [31:0] sub_word(input logic [31:0] w);
      return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
   endfunction

   function automatic logic [127:0] sub_bytes(input logic [127:0] s, input logic inv);
      logic [127:0] t;
      for (int i = 0; i < 16; i++) begin
         t[127-8*i -: 8] = inv ? REV_SBOX[s[127-8*i -: 8]] : SBOX[s[127-8*i -: 8]];
      end
      return t;
   endfunction

   // byte n is row n mod 4, column n div 4
   function automatic logic [127:0] shift_rows(input logic [127:0] s, input logic inv);
      logic [127:0] t;
      logic [1:0]   src;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            src = inv ? 2'(c - r) : 2'(c + r);
            t[127-8*(4*c+r) -: 8] = s[127-8*(4*int'(src)+r) -: 8];
         end
      end
      return t;
   endfunction

   function automatic logic [31:0] mix_col(input logic [31:0] col, input logic inv);
      logic [7:0]  a  [4];
      logic [7:0]  x2 [4];
      logic [7:0]  x4 [4];
      logic [7:0]  x8 [4];
      logic [31:0] b;
      for (int k = 0; k < 4; k++) begin
         a[k]  = col[31-8*k -: 8];
         x2[k] = xtime(a[k]);
         x4[k] = xtime(x2[k]);
         x8[k] = xtime(x4[k]);
      end
      for (int r = 0; r < 4; r++) begin
         if (inv) begin
            b[31-8*r -: 8] = (x8[r] ^ x4[r] ^ x2[r])
                           ^ (x8[(r+1)%4] ^ x2[(r+1)%4] ^ a[(r+1)%4])
                           ^ (x8[(r+2)%4] ^ x4[(r+2)%4] ^ a[(r+2)%4])
                           ^ (x8[(r+3)%4] ^ a[(r+3)%4]);
         end else begin
            b[31-8*r -: 8] = x2[r] ^ (x2[(r+1)%4] ^ a[(r+1)%4])
                           ^ a[(r+2)%4] ^ a[(r+3)%4];
         end
      end
      return b;
   endfunction

   function automatic logic [127:0] mix_columns(input logic [127:0] s, input logic inv);
      logic [127:0] t;
      for (int c = 0; c < 4; c++) begin
         t[127-32*c -: 32] = mix_col(s[127-32*c -: 32], inv);
      end
      return t;
   endfunction

endpackage
`default_nettype wire

FILE: sv/aes256_ram.sv
// ----------------------------------------------------------------------------
// AES-256 generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module aes256_ram #(
   parameter int WIDTH = 128,
   parameter int DEPTH = 15
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write and read, read data registered
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end

endmodule
`default_nettype wire

FILE: sv/aes256_ctrl.sv
// ----------------------------------------------------------------------------
// AES-256 controller
// Sequences key expansion and the rounds of one request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "aes256_block_cipher_defines.svh"
module aes256_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   input  wire aes256_pkg::status_type status,
   output logic                        busy,
   output aes256_pkg::cmd_type         cmd
);

   typedef enum logic [2:0] {ST_IDLE, ST_KLOAD, ST_KROW1, ST_KGEN, ST_RUN} state_type;

   state_type  state_ff;
   logic [5:0] cnt_ff;

   // advance state and counter
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         priority if (status.key_wr) begin
            state_ff <= ST_KLOAD;
         end else begin
            unique case (state_ff)
               ST_IDLE: begin
                  if (cmd.capture) begin
                     state_ff <= ST_RUN;
                     cnt_ff   <= '0;
                  end
               end
               ST_KLOAD: state_ff <= ST_KROW1;
               ST_KROW1: begin
                  state_ff <= ST_KGEN;
                  cnt_ff   <= 6'(aes256_pkg::FIRST_GEN);
               end
               ST_KGEN: begin
                  if (cnt_ff == 6'(aes256_pkg::LAST_WORD)) state_ff <= ST_IDLE;
                  cnt_ff <= cnt_ff + 6'd1;
               end
               ST_RUN: begin
                  if (cnt_ff == 6'(aes256_pkg::LAST_ROUND)) state_ff <= ST_IDLE;
                  cnt_ff <= cnt_ff + 6'd1;
               end
               default: state_ff <= ST_IDLE;
            endcase
         end
      end
   end

   // hold off requests while working and in any configuration write cycle
   assign busy = (state_ff != ST_IDLE) || status.cfg_wr;

   // decode commands
   always_comb begin
      cmd          = '0;
      cmd.gen_idx  = cnt_ff;
      cmd.capture  = start && !busy;
      cmd.round_en = (state_ff == ST_RUN);
      cmd.init     = (cnt_ff == 6'd0);
      cmd.last     = (cnt_ff == 6'(aes256_pkg::LAST_ROUND));
      cmd.key_load = (state_ff == ST_KLOAD);
      cmd.key_gen  = (state_ff == ST_KGEN);
      cmd.ram_we   = (state_ff == ST_KLOAD) || (state_ff == ST_KROW1)
                  || ((state_ff == ST_KGEN) && (cnt_ff[1:0] == 2'd3));
      unique case (state_ff)
         ST_KLOAD: cmd.waddr = 4'd0;
         ST_KROW1: cmd.waddr = 4'd1;
         default:  cmd.waddr = cnt_ff[5:2];
      endcase
      // fetch the key row for the next step
      if (state_ff == ST_RUN) begin
         cmd.raddr = status.decrypt ? 4'(13 - int'(cnt_ff)) : 4'(cnt_ff + 6'd1);
      end else begin
         cmd.raddr = status.decrypt ? 4'(aes256_pkg::LAST_ROUND) : 4'd0;
      end
   end

   `AES_ASSERT_NEXT(a_run_ends, clock, reset, (state_ff == ST_RUN) && cmd.last && !status.key_wr, state_ff == ST_IDLE, "run did not end after last round")
   `AES_ASSERT_SAME(a_we_key_only, clock, reset, cmd.ram_we, (state_ff == ST_KLOAD) || (state_ff == ST_KROW1) || (state_ff == ST_KGEN), "key store written outside expansion")
   `AES_ASSERT_NEXT(a_accept_busy, clock, reset, cmd.capture, busy, "accepted request did not raise busy")

endmodule
`default_nettype wire

FILE: sv/aes256_dp.sv
// ----------------------------------------------------------------------------
// AES-256 datapath
// Key registers, key expansion window, round-key store and round unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "aes256_block_cipher_defines.svh"
module aes256_dp (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire aes256_pkg::cmd_type  cmd,
   output aes256_pkg::status_type    status,
   input  wire logic                 csr_we,
   input  wire logic [2:0]           csr_index,
   input  wire logic [63:0]          csr_wdata,
   input  wire logic [63:0]          req_block_high,
   input  wire logic [63:0]          req_block_low,
   output logic                      rsp_valid,
   output logic [63:0]               rsp_out_high,
   output logic [63:0]               rsp_out_low
);

   logic [63:0]  key_ff [aes256_pkg::NUM_KEY_REGS];
   logic         mode_ff;
   logic [31:0]  win_ff [8];
   logic [7:0]   rc_ff;
   logic [7:0]   rc_in;
   logic [127:0] st_ff;
   logic [127:0] st_in;
   logic         valid_ff;
   logic [127:0] out_ff;
   logic [31:0]  gen_t;
   logic [31:0]  gen_word;
   logic [127:0] wdata;
   logic [127:0] rk;
   logic [127:0] enc_res;
   logic [127:0] dec_res;
   logic [127:0] dec_x;
   logic [127:0] res;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < aes256_pkg::NUM_KEY_REGS; i++) key_ff[i] <= '0;
         mode_ff <= 1'b0;
      end else if (csr_we) begin
         if (csr_index < aes256_pkg::CSR_MODE) key_ff[csr_index[1:0]] <= csr_wdata;
         else if (csr_index == aes256_pkg::CSR_MODE) mode_ff <= csr_wdata[0];
      end
   end

   assign status.cfg_wr  = csr_we;
   assign status.key_wr  = csr_we && (csr_index < aes256_pkg::CSR_MODE)
                        && (csr_index >= aes256_pkg::CSR_KEY0);
   assign status.decrypt = mode_ff;

   // next expanded word from the eight-word window
   always_comb begin
      gen_t = win_ff[7];
      priority if (cmd.gen_idx[2:0] == 3'd0) begin
         gen_t = aes256_pkg::sub_word({win_ff[7][23:0], win_ff[7][31:24]}) ^ {rc_ff, 24'd0};
      end else if (cmd.gen_idx[2:0] == 3'd4) begin
         gen_t = aes256_pkg::sub_word(win_ff[7]);
      end else begin
         gen_t = win_ff[7];
      end
      gen_word = win_ff[0] ^ gen_t;
      rc_in    = rc_ff;
      if (cmd.key_load) rc_in = 8'h01;
      else if (cmd.key_gen && (cmd.gen_idx[2:0] == 3'd0)) rc_in = aes256_pkg::xtime(rc_ff);
   end

   // load or shift the key window
   always_ff @(posedge clock) begin
      rc_ff <= rc_in;
      if (cmd.key_load) begin
         for (int i = 0; i < 8; i++) win_ff[i] <= key_ff[i/2][63-32*(i%2) -: 32];
      end else if (cmd.key_gen) begin
         for (int i = 0; i < 7; i++) win_ff[i] <= win_ff[i+1];
         win_ff[7] <= gen_word;
      end
   end

   // select the row written to the key store
   always_comb begin
      priority if (cmd.key_load) wdata = {key_ff[0], key_ff[1]};
      else if (cmd.key_gen) wdata = {win_ff[5], win_ff[6], win_ff[7], gen_word};
      else wdata = {win_ff[4], win_ff[5], win_ff[6], win_ff[7]};
   end

   aes256_ram #(
      .WIDTH (128),
      .DEPTH (aes256_pkg::NUM_ROWS)
   ) u_rk_ram (
      .clock (clock),
      .we    (cmd.ram_we),
      .waddr (cmd.waddr),
      .wdata (wdata),
      .raddr (cmd.raddr),
      .rdata (rk)
   );

   // initial key addition or one round, forward or inverse, and next state
   always_comb begin
      enc_res = aes256_pkg::shift_rows(aes256_pkg::sub_bytes(st_ff, 1'b0), 1'b0);
      if (!cmd.last) enc_res = aes256_pkg::mix_columns(enc_res, 1'b0);
      enc_res = enc_res ^ rk;
      dec_x   = aes256_pkg::sub_bytes(aes256_pkg::shift_rows(st_ff, 1'b1), 1'b1) ^ rk;
      dec_res = cmd.last ? dec_x : aes256_pkg::mix_columns(dec_x, 1'b1);
      priority if (cmd.init) res = st_ff ^ rk;
      else if (mode_ff) res = dec_res;
      else res = enc_res;
      priority if (cmd.capture) st_in = {req_block_high, req_block_low};
      else if (cmd.round_en) st_in = res;
      else st_in = st_ff;
   end

   // hold the state, load the result and raise the strobe on the last round
   always_ff @(posedge clock) begin
      st_ff <= st_in;
      if (cmd.round_en && cmd.last) out_ff <= res;
      if (reset) valid_ff <= 1'b0;
      else valid_ff <= cmd.round_en && cmd.last;
   end

   assign rsp_valid    = valid_ff;
   assign rsp_out_high = out_ff[127:64];
   assign rsp_out_low  = out_ff[63:0];

   `AES_ASSERT_NEXT(a_pulse, clock, reset, valid_ff, !valid_ff, "result strobe longer than one cycle")

endmodule
`default_nettype wire

FILE: sv/aes256_block_cipher.sv
// ----------------------------------------------------------------------------
// AES-256 block cipher
// One 128-bit block per request, encrypt or inverse cipher, 256-bit key.
//
// channel   ports                                   direction
// request   start, busy, req_block_high/low         in (busy back)
// result    rsp_valid, rsp_out_high/low             out, one-cycle strobe
// config    csr_we, csr_index, csr_wdata            in, write only
//
// Per request one shared round unit does the initial key addition and the
// 14 rounds, one per cycle, with the round key read from the registered key
// store in the cycle before it is used; the result is registered with its
// strobe. Each key register write starts a key expansion (one word a cycle);
// busy is high throughout, and in every configuration write cycle. Reset is
// synchronous and active high; the key store is undefined until a key is
// written. A new request is accepted while the previous result is shown.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module aes256_block_cipher (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [63:0] req_block_high,
   input  wire logic [63:0] req_block_low,
   output logic             rsp_valid,
   output logic [63:0]      rsp_out_high,
   output logic [63:0]      rsp_out_low,
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [63:0] csr_wdata
);

   aes256_pkg::cmd_type    cmd;
   aes256_pkg::status_type status;

   // sequence the work
   aes256_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .busy   (busy),
      .cmd    (cmd)
   );

   // compute rounds and keys
   aes256_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_block_high (req_block_high),
      .req_block_low  (req_block_low),
      .rsp_valid      (rsp_valid),
      .rsp_out_high   (rsp_out_high),
      .rsp_out_low    (rsp_out_low)
   );

endmodule
`default_nettype wire
